[rtl/oscl_pkg.sv]
// ----------------------------------------------------------------------------
// oscl_pkg: shared types and constants
// Request codes, transaction structs and list limits for the span clip list.
// ----------------------------------------------------------------------------
package oscl_pkg;

	localparam int MAX_RANGES = 32;
	localparam int IDX_W = $clog2(MAX_RANGES);
	localparam int CNT_W = $clog2(MAX_RANGES + 1);

	localparam logic signed [15:0] LEFT_SENTINEL  = -16'sd32767;
	localparam logic signed [15:0] RIGHT_SENTINEL = 16'sd32767;

	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_CHECK = 2'd1;
	localparam logic [1:0] REQ_VIS   = 2'd2;
	localparam logic [1:0] REQ_CLIP  = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [15:0] span_first;
		logic signed [15:0] span_last;
		logic               solid;
		logic               accept;
	} req_t;

	typedef struct packed {
		logic               frag_valid;
		logic signed [15:0] frag_first;
		logic signed [15:0] frag_last;
		logic               answer;
		logic               overflow;
		logic               is_final;
	} rsp_t;

endpackage

[rtl/occlusion_span_clip_list.sv]
// ----------------------------------------------------------------------------
// occlusion_span_clip_list: sorted occluded-range list with span clipping
// Sentinel-bounded range list in one RAM; clear, check, visibility and clip requests.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// request | in        | start & !busy      | req (req_t)
// result  | out       | strobe, no stall   | rsp (rsp_t)
//
// A request walks the list one entry at a time (address, then registered
// data). Insert and merge move one entry at a time through the RAM, a read
// then a write; a clip may walk and then shift the whole list before its
// final result.
// Reset clears the range count; RAM contents stay undefined until written.
// The receiver cannot stall: each result is shown for one cycle.
module occlusion_span_clip_list (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  oscl_pkg::req_t req,
	output logic          busy,
	output logic          strobe,
	output oscl_pkg::rsp_t rsp
);
	import oscl_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CLR1  = 4'd1;
	localparam logic [3:0] ST_WRD   = 4'd2;  // walk: read issued
	localparam logic [3:0] ST_WCHK  = 4'd3;  // walk: data back
	localparam logic [3:0] ST_GRD   = 4'd4;  // gap walk: read next
	localparam logic [3:0] ST_GCHK  = 4'd5;
	localparam logic [3:0] ST_INSR  = 4'd6;  // shift up: read k-1
	localparam logic [3:0] ST_INSW  = 4'd7;  // shift up: write k
	localparam logic [3:0] ST_MRGR  = 4'd8;  // shift down: read k
	localparam logic [3:0] ST_MRGW  = 4'd9;  // shift down: write k-shift
	localparam logic [3:0] ST_FIN   = 4'd10;

	// ram word: {start, end}
	logic               we;
	logic [IDX_W-1:0]   waddr, raddr;
	logic [31:0]        wdata, rdata;

	oscl_ram #(.WIDTH(32), .DEPTH(MAX_RANGES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [3:0]         st_q;
	req_t               req_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   i_q, nx_q, k_q;
	logic signed [15:0] si_q, enx_q;
	logic               res_q, ovf_q, upd_q;
	logic [IDX_W-1:0]   raddr_q;

	logic signed [15:0] rs, re;
	assign rs = rdata[31:16];
	assign re = rdata[15:0];
	assign raddr = raddr_q;
	assign busy = (st_q != ST_IDLE);

	logic signed [15:0] a, b;
	assign a = req_q.span_first;
	assign b = req_q.span_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			cnt_q   <= '0;
			strobe  <= 1'b0;
			we      <= 1'b0;
			raddr_q <= '0;
		end else begin
			strobe <= 1'b0;
			we     <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						req_q <= req;
						res_q <= 1'b0;
						ovf_q <= 1'b0;
						upd_q <= req.solid & req.accept;
						i_q   <= '0;
						raddr_q <= '0;
						if (req.req_type == REQ_CLEAR) begin
							we    <= 1'b1;
							waddr <= '0;
							wdata <= {LEFT_SENTINEL, req.span_first};
							st_q  <= ST_CLR1;
						end else if (req.req_type == REQ_VIS &&
						             req.span_last <= req.span_first) begin
							res_q <= 1'b0;
							st_q  <= ST_FIN;
						end else if (cnt_q == '0) begin
							res_q <= 1'b1;
							if (req.req_type == REQ_CLIP) begin
								strobe <= 1'b1;
								rsp    <= '{1'b1, req.span_first, req.span_last,
								            1'b0, 1'b0, 1'b0};
							end
							st_q <= ST_FIN;
						end else begin
							st_q <= ST_WRD;
						end
					end
				end
				ST_CLR1: begin
					we    <= 1'b1;
					waddr <= IDX_W'(1);
					wdata <= {b, RIGHT_SENTINEL};
					cnt_q <= CNT_W'(2);
					st_q  <= ST_FIN;
				end
				ST_WRD: st_q <= ST_WCHK;
				ST_WCHK: begin
					if (re < ((req_q.req_type == REQ_VIS) ? b : a)) begin
						if (i_q + 1'b1 >= cnt_q) begin
							res_q <= 1'b1;
							if (req_q.req_type == REQ_CLIP) begin
								strobe <= 1'b1;
								rsp    <= '{1'b1, a, b, 1'b0, 1'b0, 1'b0};
							end
							st_q <= ST_FIN;
						end else begin
							i_q     <= i_q + 1'b1;
							raddr_q <= raddr_q + 1'b1;
							st_q    <= ST_WRD;
						end
					end else begin
						si_q <= (upd_q && a < rs) ? a : rs;
						unique case (req_q.req_type)
							REQ_CHECK: begin
								res_q <= (a < rs) || (b > re);
								st_q  <= ST_FIN;
							end
							REQ_VIS: begin
								res_q <= !((a >= rs) && (b <= re));
								st_q  <= ST_FIN;
							end
							default: begin
								// clip
								nx_q  <= i_q;
								enx_q <= re;
								if (a < rs) begin
									res_q  <= 1'b1;
									strobe <= 1'b1;
									if (b <= rs) begin
										rsp <= '{1'b1, a, b, 1'b0, 1'b0, 1'b0};
										if (upd_q && b == rs) begin
											we <= 1'b1; waddr <= IDX_W'(i_q);
											wdata <= {a, re};
											st_q <= ST_FIN;
										end else if (upd_q &&
										             cnt_q >= CNT_W'(MAX_RANGES)) begin
											ovf_q <= 1'b1;
											st_q  <= ST_FIN;
										end else if (upd_q) begin
											k_q     <= cnt_q;
											raddr_q <= IDX_W'(cnt_q - 1'b1);
											st_q    <= (cnt_q == i_q) ? ST_INSW : ST_INSR;
										end else begin
											st_q <= ST_FIN;
										end
									end else begin
										rsp <= '{1'b1, a, rs, 1'b0, 1'b0, 1'b0};
										if (b <= re) begin
											if (upd_q) begin
												we <= 1'b1; waddr <= IDX_W'(i_q);
												wdata <= {a, re};
											end
											st_q <= ST_FIN;
										end else begin
											raddr_q <= IDX_W'(i_q + 1'b1);
											st_q <= ST_GRD;
										end
									end
								end else if (b <= re) begin
									st_q <= ST_FIN;
								end else begin
									raddr_q <= IDX_W'(i_q + 1'b1);
									st_q <= ST_GRD;
								end
							end
						endcase
					end
				end
				ST_GRD: begin
					if (nx_q + 1'b1 >= cnt_q) begin
						// tail fragment
						strobe <= 1'b1;
						rsp <= '{1'b1, enx_q, b, 1'b0, 1'b0, 1'b0};
						res_q <= 1'b1;
						st_q <= (!upd_q || nx_q == i_q) ? ST_FIN : ST_MRGR;
						k_q <= nx_q + 1'b1;
						raddr_q <= IDX_W'(nx_q + 1'b1);
						if (upd_q) begin
							we <= 1'b1; waddr <= IDX_W'(i_q);
							wdata <= {si_q, b};
						end
					end else begin
						st_q <= ST_GCHK;
					end
				end
				ST_GCHK: begin
					if (nx_q + 1'b1 >= cnt_q || b < rs) begin
						strobe <= 1'b1;
						rsp <= '{1'b1, enx_q, b, 1'b0, 1'b0, 1'b0};
						res_q <= 1'b1;
						k_q <= nx_q + 1'b1;
						raddr_q <= IDX_W'(nx_q + 1'b1);
						if (upd_q) begin
							we <= 1'b1; waddr <= IDX_W'(i_q);
							wdata <= {si_q, b};
						end
						st_q <= (!upd_q || nx_q == i_q) ? ST_FIN : ST_MRGR;
					end else begin
						strobe <= 1'b1;
						rsp <= '{1'b1, enx_q, rs, 1'b0, 1'b0, 1'b0};
						nx_q  <= nx_q + 1'b1;
						enx_q <= re;
						if (b <= re) begin
							res_q <= 1'b1;
							k_q <= nx_q + 2'd2;
							raddr_q <= IDX_W'(nx_q + 2'd2);
							if (upd_q) begin
								we <= 1'b1; waddr <= IDX_W'(i_q);
								wdata <= {si_q, re};
								st_q <= ST_MRGR;
							end else begin
								st_q <= ST_FIN;
							end
						end else begin
							raddr_q <= IDX_W'(nx_q + 2'd2);
							st_q <= ST_GRD;
						end
					end
				end
				ST_INSR: st_q <= ST_INSW;
				ST_INSW: begin
					we <= 1'b1;
					waddr <= IDX_W'(k_q);
					if (k_q == i_q) begin
						wdata <= {a, b};
						cnt_q <= cnt_q + 1'b1;
						st_q  <= ST_FIN;
					end else begin
						wdata <= rdata;
						k_q   <= k_q - 1'b1;
						raddr_q <= IDX_W'(k_q - 2'd2);
						st_q  <= (k_q - 1'b1 == i_q) ? ST_INSW : ST_INSR;
					end
				end
				ST_MRGR: begin
					if (k_q >= cnt_q) begin
						cnt_q <= cnt_q - (nx_q - i_q);
						st_q  <= ST_FIN;
					end else begin
						st_q <= ST_MRGW;
					end
				end
				ST_MRGW: begin
					we <= 1'b1;
					waddr <= IDX_W'(k_q - (nx_q - i_q));
					wdata <= rdata;
					k_q <= k_q + 1'b1;
					raddr_q <= IDX_W'(k_q + 1'b1);
					st_q <= ST_MRGR;
				end
				ST_FIN: begin
					strobe <= 1'b1;
					rsp <= '{1'b0, 16'sd0, 16'sd0, res_q, ovf_q, 1'b1};
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// final result only when the request is wrapping up
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && rsp.is_final |-> st_q == ST_IDLE)
		else $error("final result outside idle return");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RANGES))
		else $error("range count above limit");
	a_frag_nonfinal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && rsp.frag_valid |-> !rsp.is_final)
		else $error("fragment marked final");
endmodule

[rtl/oscl_ram.sv]
// ----------------------------------------------------------------------------
// oscl_ram: generic single-port-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module oscl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[tb/occlusion_span_clip_list_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// occlusion_span_clip_list_checker: result predictor and scoreboard
// Watches the request and result channels, keeps its own copy of the range
// list, predicts every result of each accepted transaction and compares.
// ----------------------------------------------------------------------------
module occlusion_span_clip_list_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  oscl_pkg::req_t req,
	input  logic           strobe,
	input  oscl_pkg::rsp_t rsp,
	output int             pending,
	output int             errors
);
	import oscl_pkg::*;

	logic signed [15:0] occ_lo [MAX_RANGES];
	logic signed [15:0] occ_hi [MAX_RANGES];
	int                 occ_cnt;
	rsp_t               rsp_expected [$];

	assign pending = rsp_expected.size();

	function automatic void push_rsp(logic v, logic signed [15:0] f, logic signed [15:0] l,
			logic a, logic o, logic fin);
		rsp_t r;
		r.frag_valid = v;
		r.frag_first = f;
		r.frag_last  = l;
		r.answer     = a;
		r.overflow   = o;
		r.is_final   = fin;
		rsp_expected.push_back(r);
	endfunction

	// first range whose end reaches key
	function automatic int first_touch(logic signed [15:0] key);
		int i;
		i = 0;
		while (i < occ_cnt && occ_hi[i] < key)
			i++;
		return i;
	endfunction

	function automatic void clip_span(logic signed [15:0] fst, logic signed [15:0] lst,
			logic sol, logic acc);
		int i, nx, k, shift;
		logic ovf, res, contained;
		logic signed [15:0] endv;
		ovf = 0;
		res = 0;
		contained = 0;
		endv = lst;
		i = first_touch(fst);
		if (i >= occ_cnt) begin
			push_rsp(1, fst, lst, 0, 0, 0);
			push_rsp(0, 0, 0, 1, 0, 1);
			return;
		end
		if (fst < occ_lo[i]) begin
			res = 1;
			if (lst <= occ_lo[i]) begin
				push_rsp(1, fst, lst, 0, 0, 0);
				if (acc && sol) begin
					if (lst == occ_lo[i]) begin
						occ_lo[i] = fst;
					end else if (occ_cnt >= MAX_RANGES) begin
						ovf = 1;
					end else begin
						for (k = occ_cnt; k > i; k--) begin
							occ_lo[k] = occ_lo[k-1];
							occ_hi[k] = occ_hi[k-1];
						end
						occ_lo[i] = fst;
						occ_hi[i] = lst;
						occ_cnt++;
					end
				end
				push_rsp(0, 0, 0, res, ovf, 1);
				return;
			end
			push_rsp(1, fst, occ_lo[i], 0, 0, 0);
			if (acc && sol)
				occ_lo[i] = fst;
		end
		if (lst <= occ_hi[i]) begin
			push_rsp(0, 0, 0, res, 0, 1);
			return;
		end
		nx = i;
		while (nx + 1 < occ_cnt && lst >= occ_lo[nx+1]) begin
			push_rsp(1, occ_hi[nx], occ_lo[nx+1], 0, 0, 0);
			nx++;
			if (lst <= occ_hi[nx]) begin
				endv = occ_hi[nx];
				contained = 1;
				break;
			end
		end
		if (!contained)
			push_rsp(1, occ_hi[nx], lst, 0, 0, 0);
		if (acc && sol) begin
			occ_hi[i] = endv;
			if (nx != i) begin
				shift = nx - i;
				for (k = nx + 1; k < occ_cnt; k++) begin
					occ_lo[k-shift] = occ_lo[k];
					occ_hi[k-shift] = occ_hi[k];
				end
				occ_cnt -= shift;
			end
		end
		push_rsp(0, 0, 0, 1, 0, 1);
	endfunction

	function automatic void predict_request(req_t q);
		int i;
		logic ans;
		case (q.req_type)
			REQ_CLEAR: begin
				occ_lo[0] = LEFT_SENTINEL;
				occ_hi[0] = q.span_first;
				occ_lo[1] = q.span_last;
				occ_hi[1] = RIGHT_SENTINEL;
				occ_cnt = 2;
				push_rsp(0, 0, 0, 0, 0, 1);
			end
			REQ_CHECK: begin
				i = first_touch(q.span_first);
				if (i >= occ_cnt)
					ans = 1;
				else
					ans = (q.span_first < occ_lo[i] || q.span_last > occ_hi[i]);
				push_rsp(0, 0, 0, ans, 0, 1);
			end
			REQ_VIS: begin
				if (q.span_last <= q.span_first) begin
					ans = 0;
				end else begin
					i = first_touch(q.span_last);
					if (i >= occ_cnt)
						ans = 1;
					else
						ans = !(q.span_first >= occ_lo[i] && q.span_last <= occ_hi[i]);
				end
				push_rsp(0, 0, 0, ans, 0, 1);
			end
			default: clip_span(q.span_first, q.span_last, q.solid, q.accept);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			occ_cnt = 0;
			errors  = 0;
			rsp_expected.delete();
		end else begin
			if (strobe) begin
				if (rsp_expected.size() == 0) begin
					$error("unexpected result transaction");
					errors++;
				end else begin
					e = rsp_expected.pop_front();
					if (rsp.frag_valid !== e.frag_valid) begin
						$error("frag_valid expected %0d got %0d", e.frag_valid, rsp.frag_valid);
						errors++;
					end
					if (rsp.frag_first !== e.frag_first) begin
						$error("frag_first expected %0d got %0d", e.frag_first, rsp.frag_first);
						errors++;
					end
					if (rsp.frag_last !== e.frag_last) begin
						$error("frag_last expected %0d got %0d", e.frag_last, rsp.frag_last);
						errors++;
					end
					if (rsp.answer !== e.answer) begin
						$error("answer expected %0d got %0d", e.answer, rsp.answer);
						errors++;
					end
					if (rsp.overflow !== e.overflow) begin
						$error("overflow expected %0d got %0d", e.overflow, rsp.overflow);
						errors++;
					end
					if (rsp.is_final !== e.is_final) begin
						$error("is_final expected %0d got %0d", e.is_final, rsp.is_final);
						errors++;
					end
				end
			end
			if (start && !busy)
				predict_request(req);
		end
	end
endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the span clip list
// Drives directed and random requests with random gaps; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import oscl_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic strobe;
	rsp_t rsp;
	int   pending;
	int   errors;
	int   cycles;

	occlusion_span_clip_list dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .strobe(strobe), .rsp(rsp)
	);

	occlusion_span_clip_list_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.strobe(strobe), .rsp(rsp), .pending(pending), .errors(errors)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic logic signed [15:0] any_col();
		return 16'($urandom_range(0, 65534) - 32767);
	endfunction

	task automatic send(logic [1:0] t, logic signed [15:0] f, logic signed [15:0] l,
			logic s, logic a, bit may_idle);
		int gap;
		req.req_type   <= t;
		req.span_first <= f;
		req.span_last  <= l;
		req.solid      <= s;
		req.accept     <= a;
		start          <= 1'b1;
		do @(posedge clk); while (busy);
		gap = 0;
		if (may_idle)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int n, w, pos;
		bit idle_on;
		logic [1:0] t;
		start = 0;
		req   = '0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty list: clip and queries walk nothing
		send(REQ_CHECK, -5, 5, 0, 0, 1);
		send(REQ_VIS, 5, 5, 0, 0, 1);
		send(REQ_CLIP, -7, 7, 1, 1, 1);
		send(REQ_CLEAR, -16'sd32767, 16'sd32767, 0, 0, 1);
		send(REQ_CLIP, 16'sd32767, -16'sd32767, 1, 1, 0);
		send(REQ_CLEAR, -100, 100, 0, 0, 0);
		send(REQ_CLIP, -20, -10, 1, 1, 0);
		send(REQ_CLIP, -30, -20, 1, 1, 0);
		send(REQ_CLIP, 10, 20, 1, 0, 0);
		send(REQ_CLIP, 10, 20, 0, 1, 0);
		send(REQ_CLIP, 30, 40, 1, 1, 0);
		send(REQ_CLIP, -25, 35, 0, 1, 1);
		send(REQ_CLIP, -110, 110, 1, 1, 1);
		send(REQ_CHECK, -50, 50, 0, 0, 1);
		send(REQ_VIS, -50, 50, 0, 0, 1);
		send(REQ_VIS, 9, 3, 0, 0, 1);
		send(REQ_CLIP, 20, 10, 1, 1, 1);
		// fill the list to the top, then one more insert overflows
		send(REQ_CLEAR, -1000, 1000, 0, 0, 0);
		for (int k = 0; k < 31; k++)
			send(REQ_CLIP, 16'(-900 + 10 * k), 16'(-895 + 10 * k), 1, 1, 0);

		// hold until all results have drained
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);

		n = 0;
		idle_on = 1;
		while (n < 320) begin
			if (n % 60 == 0)
				idle_on = ($urandom_range(0, 2) != 0);
			if (n % 45 == 0) begin
				send(REQ_CLEAR, 16'(-$urandom_range(100, 300)), 16'($urandom_range(100, 300)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), idle_on);
			end else if ($urandom_range(0, 19) == 0) begin
				t = 2'($urandom_range(0, 3));
				send(t, any_col(), any_col(), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), idle_on);
			end else begin
				pos = $urandom_range(0, 640) - 320;
				w = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 5);
				if ($urandom_range(0, 3) == 0)
					t = 2'($urandom_range(1, 2));
				else
					t = REQ_CLIP;
				send(t, 16'(pos), 16'(pos + w), $urandom_range(0, 5) != 0,
					$urandom_range(0, 5) != 0, idle_on);
			end
			n++;
		end
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

[sim.f]
rtl/oscl_pkg.sv
rtl/oscl_ram.sv
rtl/occlusion_span_clip_list.sv
tb/occlusion_span_clip_list_checker.sv
tb/testbench.sv
